[rtl/vr2d_pkg.sv]
package vr2d_pkg;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;

	typedef struct packed {
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic [30:0]        new_length;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic               zero_vector;
	} out_beat_t;

	typedef struct packed {
		logic [31:0] mx;
		logic [31:0] my;
		logic [30:0] tgt;
		logic        nx;
		logic        ny;
		logic        zero;
	} meta_t;

	typedef struct packed {
		logic nx;
		logic ny;
		logic zero;
	} flags_t;

endpackage

[rtl/vr2d_front.sv]
module vr2d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              vld,
	input  vr2d_pkg::in_beat_t beat,
	output logic              vld_o,
	output vr2d_pkg::meta_t   meta_o,
	output logic [63:0]       sum_o
);

	vr2d_pkg::meta_t meta_c, meta_s1, meta_s2, meta_s3;
	logic            vld_s1, vld_s2, vld_s3;
	logic [63:0]     sqx_s2, sqy_s2, sum_s3;

	always_comb begin
		meta_c.nx   = beat.in_x[31];
		meta_c.ny   = beat.in_y[31];
		meta_c.mx   = beat.in_x[31] ? (~beat.in_x + 32'd1) : beat.in_x;
		meta_c.my   = beat.in_y[31] ? (~beat.in_y + 32'd1) : beat.in_y;
		meta_c.tgt  = beat.new_length;
		meta_c.zero = (beat.in_x == 32'sd0) && (beat.in_y == 32'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= meta_c;
			meta_s2 <= meta_s1;
			sqx_s2  <= {32'd0, meta_s1.mx} * {32'd0, meta_s1.mx};
			sqy_s2  <= {32'd0, meta_s1.my} * {32'd0, meta_s1.my};
			meta_s3 <= meta_s2;
			sum_s3  <= sqx_s2 + sqy_s2;
		end
	end

	assign vld_o  = vld_s3;
	assign meta_o = meta_s3;
	assign sum_o  = sum_s3;

endmodule

[rtl/vr2d_isqrt.sv]
module vr2d_isqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            vld,
	input  vr2d_pkg::meta_t meta,
	input  logic [63:0]     sum,
	output logic            vld_o,
	output vr2d_pkg::meta_t meta_o,
	output logic [31:0]     len_o
);

	logic [63:0]     rem_s  [0:vr2d_pkg::SQRT_STEPS];
	logic [63:0]     root_s [0:vr2d_pkg::SQRT_STEPS];
	vr2d_pkg::meta_t meta_s [0:vr2d_pkg::SQRT_STEPS];
	logic            vld_s  [0:vr2d_pkg::SQRT_STEPS];

	assign rem_s[0]  = sum;
	assign root_s[0] = 64'd0;
	assign meta_s[0] = meta;
	assign vld_s[0]  = vld;

	for (genvar i = 0; i < vr2d_pkg::SQRT_STEPS; i++) begin : g_step
		localparam logic [63:0] ROOT_BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] trial;
		logic        take;

		assign trial = root_s[i] + ROOT_BIT;
		assign take  = rem_s[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				meta_s[i+1] <= meta_s[i];
				rem_s[i+1]  <= take ? (rem_s[i] - trial) : rem_s[i];
				root_s[i+1] <= take ? ((root_s[i] >> 1) + ROOT_BIT) : (root_s[i] >> 1);
			end
		end
	end

	assign vld_o  = vld_s[vr2d_pkg::SQRT_STEPS];
	assign meta_o = meta_s[vr2d_pkg::SQRT_STEPS];
	assign len_o  = root_s[vr2d_pkg::SQRT_STEPS][31:0];

endmodule

[rtl/vr2d_div.sv]
module vr2d_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        vld,
	input  logic [31:0] mag,
	input  logic [30:0] tgt,
	input  logic [31:0] den,
	output logic        vld_o,
	output logic [30:0] quo_o
);

	logic [62:0] rem_s [0:vr2d_pkg::DIV_STEPS];
	logic [31:0] den_s [0:vr2d_pkg::DIV_STEPS];
	logic [30:0] quo_s [0:vr2d_pkg::DIV_STEPS];
	logic        vld_s [0:vr2d_pkg::DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= {31'd0, mag} * {32'd0, tgt} + {32'd0, den[31:1]};
			den_s[0] <= den;
		end
	end

	assign quo_s[0] = 31'd0;

	for (genvar i = 0; i < vr2d_pkg::DIV_STEPS; i++) begin : g_step
		logic [62:0] sub;
		logic        take;

		assign sub  = {31'd0, den_s[i]} << (vr2d_pkg::DIV_STEPS - 1 - i);
		assign take = rem_s[i] >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1] <= take ? (rem_s[i] - sub) : rem_s[i];
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= {quo_s[i][29:0], take};
			end
		end
	end

	assign vld_o = vld_s[vr2d_pkg::DIV_STEPS];
	assign quo_o = quo_s[vr2d_pkg::DIV_STEPS];

endmodule

[rtl/vector_resize_2d_core.sv]
// Throughput is one beat per cycle while not stalled: 3 square-and-sum stages, 32 root stages,
// a multiply stage, 31 divider stages (one quotient bit each) and the output register.
// A stall while the output holds a valid beat freezes the whole pipeline in place.
// Reset clears all valid bits asynchronously; data registers are not reset.
module vector_resize_2d_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  vr2d_pkg::in_beat_t  src_data,
	output logic                dst_valid,
	input  logic                dst_stall,
	output vr2d_pkg::out_beat_t dst_data
);

	logic                adv;
	logic                fr_vld, sq_vld, dx_vld, dy_vld;
	vr2d_pkg::meta_t     fr_meta, sq_meta;
	logic [63:0]         fr_sum;
	logic [31:0]         len, den;
	logic [30:0]         qx, qy;
	vr2d_pkg::flags_t    flag_s [0:vr2d_pkg::DIV_STEPS];
	logic                out_vld_q;
	vr2d_pkg::out_beat_t out_q;

	assign adv       = !out_vld_q || !dst_stall;
	assign src_stall = !adv;

	vr2d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld    (src_valid),
		.beat   (src_data),
		.vld_o  (fr_vld),
		.meta_o (fr_meta),
		.sum_o  (fr_sum)
	);

	vr2d_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld    (fr_vld),
		.meta   (fr_meta),
		.sum    (fr_sum),
		.vld_o  (sq_vld),
		.meta_o (sq_meta),
		.len_o  (len)
	);

	assign den = (len == 32'd0) ? 32'd1 : len;

	vr2d_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld    (sq_vld),
		.mag    (sq_meta.mx),
		.tgt    (sq_meta.tgt),
		.den    (den),
		.vld_o  (dx_vld),
		.quo_o  (qx)
	);

	vr2d_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld    (sq_vld),
		.mag    (sq_meta.my),
		.tgt    (sq_meta.tgt),
		.den    (den),
		.vld_o  (dy_vld),
		.quo_o  (qy)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			flag_s[0] <= '{nx: sq_meta.nx, ny: sq_meta.ny, zero: sq_meta.zero};
		end
	end

	for (genvar i = 0; i < vr2d_pkg::DIV_STEPS; i++) begin : g_flag
		always_ff @(posedge clk) begin
			if (adv) begin
				flag_s[i+1] <= flag_s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= dx_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (flag_s[vr2d_pkg::DIV_STEPS].zero) begin
				out_q.out_x <= 32'sd0;
				out_q.out_y <= 32'sd0;
			end else begin
				out_q.out_x <= flag_s[vr2d_pkg::DIV_STEPS].nx ? (32'sd0 - {1'b0, qx}) : {1'b0, qx};
				out_q.out_y <= flag_s[vr2d_pkg::DIV_STEPS].ny ? (32'sd0 - {1'b0, qy}) : {1'b0, qy};
			end
			out_q.zero_vector <= flag_s[vr2d_pkg::DIV_STEPS].zero;
		end
	end

	assign dst_valid = out_vld_q;
	assign dst_data  = out_q;

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dx_vld == dy_vld) else $error("divider lanes out of step");

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.zero_vector) |-> (out_q.out_x == 32'sd0 && out_q.out_y == 32'sd0))
		else $error("zero vector with nonzero output");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && dst_stall) |=> ($stable(dx_vld) && $stable(qx) && $stable(qy)))
		else $error("pipeline moved during stall");

endmodule

[dv/tb_vector_resize_2d_core.sv]
`timescale 1ns / 1ps

module tb_vector_resize_2d_core;

	class resize_scoreboard;
		vr2d_pkg::out_beat_t expected_q[$];
		int errors;

		function logic [63:0] root_floor(logic [63:0] v);
			logic [63:0] res;
			logic [63:0] bitpos;
			res = 0;
			bitpos = 64'd1 << 62;
			while (bitpos > v) bitpos = bitpos >> 2;
			while (bitpos != 0) begin
				if (v >= res + bitpos) begin
					v = v - (res + bitpos);
					res = (res >> 1) + bitpos;
				end else begin
					res = res >> 1;
				end
				bitpos = bitpos >> 2;
			end
			return res;
		endfunction

		function logic [31:0] scale(logic [63:0] mag, logic neg, logic [63:0] tgt,
			logic [63:0] len);
			logic [63:0] q;
			q = (mag * tgt + (len >> 1)) / len;
			if (neg) begin
				if (q > 64'h8000_0000) q = 64'h8000_0000;
				return 32'(-q);
			end
			if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
			return q[31:0];
		endfunction

		function void note_input(vr2d_pkg::in_beat_t b);
			vr2d_pkg::out_beat_t e;
			logic [63:0] mx, my, len;
			logic nx, ny;
			nx = b.in_x[31];
			ny = b.in_y[31];
			mx = nx ? 64'h1_0000_0000 - {32'd0, b.in_x} : {32'd0, b.in_x};
			my = ny ? 64'h1_0000_0000 - {32'd0, b.in_y} : {32'd0, b.in_y};
			e = '0;
			if (mx == 0 && my == 0) begin
				e.zero_vector = 1'b1;
			end else begin
				len = root_floor(mx * mx + my * my);
				if (len == 0) len = 1;
				e.out_x = scale(mx, nx, {33'd0, b.new_length}, len);
				e.out_y = scale(my, ny, {33'd0, b.new_length}, len);
			end
			expected_q.push_back(e);
		endfunction

		function void check_result(vr2d_pkg::out_beat_t r);
			vr2d_pkg::out_beat_t e;
			if (expected_q.size() == 0) begin
				$error("Unexpected output beat %h", r);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (r.out_x !== e.out_x) begin
				$error("out_x expected %h actual %h", e.out_x, r.out_x);
				errors++;
			end
			if (r.out_y !== e.out_y) begin
				$error("out_y expected %h actual %h", e.out_y, r.out_y);
				errors++;
			end
			if (r.zero_vector !== e.zero_vector) begin
				$error("zero_vector expected %b actual %b", e.zero_vector, r.zero_vector);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic src_valid;
	logic src_stall;
	vr2d_pkg::in_beat_t src_data;
	logic dst_valid;
	logic dst_stall;
	vr2d_pkg::out_beat_t dst_data;

	resize_scoreboard sb;
	int src_idle_pct;
	int dst_idle_pct;
	bit hold_dst;
	int quiet_cycles;

	localparam int QUIET_LIMIT = 5000;

	vector_resize_2d_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data(src_data),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_data(dst_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function logic [31:0] rand_component();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 8)) - 4);
			3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			4: return 32'h0;
			default: return $urandom();
		endcase
	endfunction

	function logic [30:0] rand_length();
		case ($urandom_range(0, 5))
			0: return 31'h0001_0000;
			1: return 31'h7FFF_FFFF;
			2: return 31'd0;
			3: return 31'($urandom_range(0, 1 << 22));
			default: return 31'($urandom());
		endcase
	endfunction

	task automatic send_beat(logic [31:0] x, logic [31:0] y, logic [30:0] l);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_data <= '{in_x: x, in_y: y, new_length: l};
		do @(posedge clk); while (src_stall);
		sb.note_input(src_data);
		@(negedge clk);
	endtask

	task automatic send_random(int n);
		repeat (n) send_beat(rand_component(), rand_component(), rand_length());
	endtask

	task automatic wait_drained();
		src_valid <= 1'b0;
		do @(negedge clk); while (sb.expected_q.size() != 0);
	endtask

	always @(negedge clk) begin
		dst_stall <= hold_dst || ($urandom_range(0, 99) < dst_idle_pct);
	end

	always @(posedge clk) begin
		if (dst_valid && !dst_stall) sb.check_result(dst_data);
		if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		sb = new();
		src_valid = 1'b0;
		src_data = '0;
		dst_stall = 1'b0;
		hold_dst = 1'b0;
		quiet_cycles = 0;
		src_idle_pct = 0;
		dst_idle_pct = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_beat(32'h0, 32'h0, 31'h0001_0000);
		send_beat(32'h0, 32'h0, 31'h7FFF_FFFF);
		send_beat(32'h8000_0000, 32'h0, 31'h7FFF_FFFF);
		send_beat(32'h0, 32'h8000_0000, 31'h7FFF_FFFF);
		send_beat(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
		send_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
		send_beat(32'h7FFF_FFFF, 32'h8000_0000, 31'h0001_0000);
		send_beat(32'h0003_0000, 32'h0004_0000, 31'h0001_0000);
		send_beat(32'hFFFD_0000, 32'hFFFC_0000, 31'h000A_0000);
		send_beat(32'h1, 32'h0, 31'h7FFF_FFFF);
		send_beat(32'hFFFF_FFFF, 32'h1, 31'h7FFF_FFFF);
		send_beat(32'h1, 32'h1, 31'h1);
		send_beat(32'h1234_5678, 32'hEDCB_A988, 31'd0);
		send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h5555_5555);
		send_beat(32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA);
		wait_drained();

		// Hold the output so the pipeline fills and backs up into the input.
		fork
			begin
				hold_dst = 1'b1;
				repeat (200) @(posedge clk);
				hold_dst = 1'b0;
			end
			send_random(120);
		join
		wait_drained();

		src_idle_pct = 37;
		dst_idle_pct = 55;
		send_random(560);
		src_idle_pct = 55;
		dst_idle_pct = 37;
		send_random(560);
		wait_drained();
		src_idle_pct = 0;
		dst_idle_pct = 0;
		send_random(560);
		wait_drained();
		repeat (100) @(posedge clk);

		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
